/* hdl/ecpsm_pkg.sv */
// ecpsm_pkg: shared types and opcodes for the elliptic-curve point unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ecpsm_pkg;

    typedef enum logic [1:0] {
        FOP_ADD = 2'd0,
        FOP_SUB = 2'd1,
        FOP_MUL = 2'd2,
        FOP_RED = 2'd3
    } fop_t;

    localparam logic CFG_CURVE_A = 1'b0;
    localparam logic CFG_MODULUS = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE,
        S_RED_A, S_RED_UX, S_RED_UY, S_RED_VX, S_RED_VY,
        S_DISPATCH,
        S_SCALE_NEXT,
        // point add / double
        S_PA_CHECK,
        S_PD_T1, S_PD_T2, S_PD_T3, S_PD_DEN,
        S_PA_NUM, S_PA_DEN,
        S_INV_SQ, S_INV_MUL,
        S_LAM, S_LAM2, S_RX1, S_RX2, S_DX, S_RY1, S_RY2,
        S_PA_DONE,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        fop_t op;
    } fu_cmd_t;

endpackage
`default_nettype wire

/* hdl/ec_point_add_scalar_mult.sv */
// Usage: streaming point unit. s_axis carries one request word, m_axis one result word,
// cfg writes curve_a (index 0) and prime_modulus (index 1), each masked to FIELD_WIDTH.
// Request: tuser = req_type (0 add, 1 scalar multiply); tdata packs first_x, first_y,
// second_x, second_y, scalar from bit 0 up. Result: tdata = result_x, result_y;
// tuser = at_infinity. (0,0) encodes infinity.
// Cost: every field multiply and every input reduction runs on one bit-serial
// modular unit, as do adds and subtracts. A point op costs one inversion (up to
// 2*FIELD_WIDTH multiplies) plus three or four multiplies; a scalar multiply runs
// up to 2*FIELD_WIDTH point ops. One request at a time: s_tready is high only when
// idle. The result is held in an output register until m_axis_tready; the next
// request is taken once it is read.
// Reset: clears control, curve_a = 0, prime_modulus = 2^64-59 masked to the width.
// A modulus below three answers infinity for every request.
`timescale 1ns / 1ps
`default_nettype none
module ec_point_add_scalar_mult #(
    parameter int FIELD_WIDTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic                     cfg_index,
    input  wire logic [63:0]              cfg_data,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // first_x, first_y, second_x, second_y, scalar
    input  wire logic [8*((5*FIELD_WIDTH+7)/8)-1:0] s_axis_tdata,
    // req_type
    input  wire logic                     s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // result_x, result_y
    output logic [8*((2*FIELD_WIDTH+7)/8)-1:0] m_axis_tdata,
    // at_infinity
    output logic                          m_axis_tuser
);
    localparam int W  = FIELD_WIDTH;
    localparam int CW = $clog2(W + 1);
    localparam int OW = 8*((2*FIELD_WIDTH+7)/8);
    localparam logic [63:0] MOD_RESET = 64'd18446744073709551557;

    ecpsm_pkg::state_t state_reg, state_next;
    ecpsm_pkg::state_t ret_reg, ret_next;

    logic [W-1:0] a_reg, p_reg;
    logic [W-1:0] ca_reg, ca_next;
    logic [W-1:0] ux_reg, ux_next, uy_reg, uy_next;
    logic [W-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic [W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [W-1:0] m_reg, m_next;
    logic [W-1:0] t_reg, t_next, n_reg, n_next, l_reg, l_next;
    logic [W-1:0] e_reg, e_next;
    logic [CW-1:0] ic_reg, ic_next;
    logic         sc_reg, sc_next;
    logic         dbl_reg, dbl_next;
    logic         go_reg, go_next;
    logic         ov_reg, ov_next;
    logic [W-1:0] ox_reg, ox_next, oy_reg, oy_next;

    ecpsm_pkg::fu_cmd_t cmd;
    logic [W-1:0] fa, fb, fres;
    logic         fdone;

    // point-op operands for an add request: P=(ux,uy) first, Q=(vx,vy) second; result to (rx,ry)
    logic [W-1:0] px, py, qx, qy;

    ecpsm_fu #(.W(W)) u_fu (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .opa(fa), .opb(fb),
        .modulus(p_reg), .done(fdone), .res(fres)
    );

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ecpsm_pkg::S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = OW'({oy_reg, ox_reg});
    assign m_axis_tuser  = (ox_reg == '0) && (oy_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            p_reg <= MOD_RESET[W-1:0];
        end
        else if (cfg_valid)
        begin
            if (cfg_index == ecpsm_pkg::CFG_CURVE_A)
                a_reg <= cfg_data[W-1:0];
            else
                p_reg <= cfg_data[W-1:0];
        end
    end

    // operand selection for point ops: in scalar mode P=R, Q=power for add;
    // doubling always uses (px,py)
    always_comb
    begin
        if (sc_reg && !dbl_reg)
        begin
            px = rx_reg; py = ry_reg; qx = ux_reg; qy = uy_reg;
        end
        else
        begin
            px = ux_reg; py = uy_reg; qx = vx_reg; qy = vy_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ecpsm_pkg::S_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                    state_next = (p_reg < W'(3)) ? ecpsm_pkg::S_OUT : ecpsm_pkg::S_RED_A;
            ecpsm_pkg::S_RED_A:  if (fdone) state_next = ecpsm_pkg::S_RED_UX;
            ecpsm_pkg::S_RED_UX: if (fdone) state_next = ecpsm_pkg::S_RED_UY;
            ecpsm_pkg::S_RED_UY: if (fdone) state_next = ecpsm_pkg::S_RED_VX;
            ecpsm_pkg::S_RED_VX: if (fdone) state_next = ecpsm_pkg::S_RED_VY;
            ecpsm_pkg::S_RED_VY: if (fdone) state_next = ecpsm_pkg::S_DISPATCH;
            ecpsm_pkg::S_DISPATCH:
                if (!sc_reg) state_next = ecpsm_pkg::S_PA_CHECK;
                else if (m_reg == '0) state_next = ecpsm_pkg::S_OUT;
                else state_next = ecpsm_pkg::S_SCALE_NEXT;
            ecpsm_pkg::S_SCALE_NEXT:
                if (m_reg[W-1:1] == '0) state_next = ecpsm_pkg::S_OUT;
                else state_next = ecpsm_pkg::S_PA_CHECK;
            ecpsm_pkg::S_PA_CHECK:
            begin
                if (dbl_reg)
                    state_next = (py == '0) ? ecpsm_pkg::S_PA_DONE : ecpsm_pkg::S_PD_T1;
                else if ((px == '0 && py == '0) || (qx == '0 && qy == '0))
                    state_next = ecpsm_pkg::S_PA_DONE;
                else if (px == qx)
                    state_next = (py == qy && py != '0) ? ecpsm_pkg::S_PD_T1
                                                       : ecpsm_pkg::S_PA_DONE;
                else
                    state_next = ecpsm_pkg::S_PA_NUM;
            end
            ecpsm_pkg::S_PD_T1:  if (fdone) state_next = ecpsm_pkg::S_PD_T2;
            ecpsm_pkg::S_PD_T2:  if (fdone) state_next = ecpsm_pkg::S_PD_T3;
            ecpsm_pkg::S_PD_T3:  if (fdone) state_next = ecpsm_pkg::S_PD_DEN;
            ecpsm_pkg::S_PD_DEN: if (fdone) state_next = ecpsm_pkg::S_INV_SQ;
            ecpsm_pkg::S_PA_NUM: if (fdone) state_next = ecpsm_pkg::S_PA_DEN;
            ecpsm_pkg::S_PA_DEN: if (fdone) state_next = ecpsm_pkg::S_INV_SQ;
            ecpsm_pkg::S_INV_SQ:
                if (fdone) state_next = e_reg[W-1] ? ecpsm_pkg::S_INV_MUL
                                       : (ic_reg == CW'(1) ? ecpsm_pkg::S_LAM
                                                           : ecpsm_pkg::S_INV_SQ);
            ecpsm_pkg::S_INV_MUL:
                if (fdone) state_next = (ic_reg == CW'(1)) ? ecpsm_pkg::S_LAM
                                                           : ecpsm_pkg::S_INV_SQ;
            ecpsm_pkg::S_LAM:  if (fdone) state_next = ecpsm_pkg::S_LAM2;
            ecpsm_pkg::S_LAM2: if (fdone) state_next = ecpsm_pkg::S_RX1;
            ecpsm_pkg::S_RX1:  if (fdone) state_next = ecpsm_pkg::S_RX2;
            ecpsm_pkg::S_RX2:  if (fdone) state_next = ecpsm_pkg::S_DX;
            ecpsm_pkg::S_DX:   if (fdone) state_next = ecpsm_pkg::S_RY1;
            ecpsm_pkg::S_RY1:  if (fdone) state_next = ecpsm_pkg::S_RY2;
            ecpsm_pkg::S_RY2:  if (fdone) state_next = ecpsm_pkg::S_PA_DONE;
            ecpsm_pkg::S_PA_DONE:
                state_next = sc_reg ? ecpsm_pkg::S_SCALE_NEXT : ecpsm_pkg::S_OUT;
            ecpsm_pkg::S_OUT: state_next = ecpsm_pkg::S_IDLE;
            default: state_next = ecpsm_pkg::S_IDLE;
        endcase
    end

    // field-unit command: issued on state entry or on a new inversion step (go_reg) while waiting
    always_comb
    begin
        cmd.start = go_reg;
        cmd.op    = ecpsm_pkg::FOP_MUL;
        fa = '0;
        fb = '0;
        unique case (state_reg)
            ecpsm_pkg::S_RED_A:  begin cmd.op = ecpsm_pkg::FOP_RED; fb = a_reg;  end
            ecpsm_pkg::S_RED_UX: begin cmd.op = ecpsm_pkg::FOP_RED; fb = ux_reg; end
            ecpsm_pkg::S_RED_UY: begin cmd.op = ecpsm_pkg::FOP_RED; fb = uy_reg; end
            ecpsm_pkg::S_RED_VX: begin cmd.op = ecpsm_pkg::FOP_RED; fb = vx_reg; end
            ecpsm_pkg::S_RED_VY: begin cmd.op = ecpsm_pkg::FOP_RED; fb = vy_reg; end
            ecpsm_pkg::S_PD_T1:  begin fa = px; fb = px; end
            ecpsm_pkg::S_PD_T2:  begin cmd.op = ecpsm_pkg::FOP_ADD; fa = t_reg; fb = t_reg; end
            ecpsm_pkg::S_PD_T3:  begin cmd.op = ecpsm_pkg::FOP_ADD; fa = n_reg; fb = t_reg; end
            ecpsm_pkg::S_PD_DEN: begin cmd.op = ecpsm_pkg::FOP_ADD; fa = py; fb = py; end
            ecpsm_pkg::S_PA_NUM: begin cmd.op = ecpsm_pkg::FOP_SUB; fa = py; fb = qy; end
            ecpsm_pkg::S_PA_DEN: begin cmd.op = ecpsm_pkg::FOP_SUB; fa = px; fb = qx; end
            ecpsm_pkg::S_INV_SQ: begin fa = l_reg; fb = l_reg; end
            ecpsm_pkg::S_INV_MUL: begin fa = l_reg; fb = t_reg; end
            ecpsm_pkg::S_LAM:    begin fa = n_reg; fb = l_reg; end
            ecpsm_pkg::S_LAM2:   begin fa = l_reg; fb = l_reg; end
            ecpsm_pkg::S_RX1:    begin cmd.op = ecpsm_pkg::FOP_SUB; fa = t_reg; fb = px; end
            ecpsm_pkg::S_RX2:    begin cmd.op = ecpsm_pkg::FOP_SUB; fa = t_reg;
                                       fb = dbl_reg ? px : qx; end
            ecpsm_pkg::S_DX:     begin cmd.op = ecpsm_pkg::FOP_SUB; fa = px; fb = n_reg; end
            ecpsm_pkg::S_RY1:    begin fa = l_reg; fb = t_reg; end
            ecpsm_pkg::S_RY2:    begin cmd.op = ecpsm_pkg::FOP_SUB; fa = t_reg; fb = py; end
            default:             cmd.start = 1'b0;
        endcase
    end

    always_comb
    begin
        ca_next = ca_reg; ux_next = ux_reg; uy_next = uy_reg;
        vx_next = vx_reg; vy_next = vy_reg; rx_next = rx_reg; ry_next = ry_reg;
        m_next = m_reg; t_next = t_reg; n_next = n_reg; l_next = l_reg;
        e_next = e_reg; ic_next = ic_reg; sc_next = sc_reg; dbl_next = dbl_reg;
        ret_next = ret_reg;
        ov_next = ov_reg; ox_next = ox_reg; oy_next = oy_reg;
        go_next = (state_next != state_reg) ||
                  (fdone && (state_reg == ecpsm_pkg::S_INV_SQ ||
                             state_reg == ecpsm_pkg::S_INV_MUL));
        if (m_axis_tready && ov_reg)
            ov_next = 1'b0;
        unique case (state_reg)
            ecpsm_pkg::S_IDLE:
                if (s_axis_tvalid && s_axis_tready)
                begin
                    ux_next = s_axis_tdata[0*W +: W];
                    uy_next = s_axis_tdata[1*W +: W];
                    vx_next = s_axis_tdata[2*W +: W];
                    vy_next = s_axis_tdata[3*W +: W];
                    m_next  = s_axis_tdata[4*W +: W];
                    sc_next = s_axis_tuser;
                    rx_next = '0;
                    ry_next = '0;
                    dbl_next = 1'b0;
                end
            ecpsm_pkg::S_RED_A:  if (fdone) ca_next = fres;
            ecpsm_pkg::S_RED_UX: if (fdone) ux_next = fres;
            ecpsm_pkg::S_RED_UY: if (fdone) uy_next = fres;
            ecpsm_pkg::S_RED_VX: if (fdone) vx_next = fres;
            ecpsm_pkg::S_RED_VY: if (fdone) vy_next = fres;
            ecpsm_pkg::S_DISPATCH:
                if (sc_reg && m_reg[0])
                begin
                    rx_next = ux_reg;
                    ry_next = uy_reg;
                end
            ecpsm_pkg::S_SCALE_NEXT:
            begin
                // advance: double the power; add into R if the next bit is set
                m_next   = m_reg >> 1;
                dbl_next = 1'b1;
            end
            ecpsm_pkg::S_PA_CHECK:
            begin
                e_next  = p_reg - W'(2);
                ic_next = CW'(W);
                l_next  = W'(1);
                if (!dbl_reg && !(px == '0 && py == '0) && !(qx == '0 && qy == '0) &&
                    px == qx && py == qy && py != '0)
                begin
                    // equal points: double P in place via the P operands
                    dbl_next = 1'b1;
                    ret_next = ecpsm_pkg::S_PA_CHECK;
                end
                else
                    ret_next = ecpsm_pkg::S_IDLE;
            end
            ecpsm_pkg::S_PD_T1:  if (fdone) t_next = fres;
            ecpsm_pkg::S_PD_T2:  if (fdone) n_next = fres;
            ecpsm_pkg::S_PD_T3:  if (fdone) t_next = fres;
            ecpsm_pkg::S_PD_DEN:
                if (fdone)
                begin
                    n_next = (t_reg + ca_reg >= p_reg || t_reg + ca_reg < t_reg)
                             ? W'(t_reg + ca_reg - p_reg) : W'(t_reg + ca_reg);
                    t_next = fres;
                end
            ecpsm_pkg::S_PA_NUM: if (fdone) n_next = fres;
            ecpsm_pkg::S_PA_DEN: if (fdone) t_next = fres;
            ecpsm_pkg::S_INV_SQ:
                if (fdone)
                begin
                    l_next = fres;
                    if (!e_reg[W-1])
                    begin
                        e_next  = e_reg << 1;
                        ic_next = ic_reg - 1'b1;
                    end
                end
            ecpsm_pkg::S_INV_MUL:
                if (fdone)
                begin
                    l_next  = fres;
                    e_next  = e_reg << 1;
                    ic_next = ic_reg - 1'b1;
                end
            ecpsm_pkg::S_LAM:  if (fdone) l_next = fres;
            ecpsm_pkg::S_LAM2: if (fdone) t_next = fres;
            ecpsm_pkg::S_RX1:  if (fdone) t_next = fres;
            ecpsm_pkg::S_RX2:  if (fdone) n_next = fres;
            ecpsm_pkg::S_DX:   if (fdone) t_next = fres;
            ecpsm_pkg::S_RY1:  if (fdone) t_next = fres;
            ecpsm_pkg::S_RY2:  if (fdone) e_next = fres;
            ecpsm_pkg::S_PA_DONE:
            begin
                // commit the point result
                if (!sc_reg)
                begin
                    if (ret_reg == ecpsm_pkg::S_PA_CHECK)
                    begin
                        rx_next = n_reg; ry_next = e_reg;
                    end
                    else if (px == '0 && py == '0)
                    begin
                        rx_next = qx; ry_next = qy;
                    end
                    else if (qx == '0 && qy == '0)
                    begin
                        rx_next = px; ry_next = py;
                    end
                    else if (px == qx)
                    begin
                        rx_next = '0; ry_next = '0;
                    end
                    else
                    begin
                        rx_next = n_reg; ry_next = e_reg;
                    end
                end
                else if (dbl_reg && ret_reg != ecpsm_pkg::S_PA_CHECK)
                begin
                    // finished doubling the power
                    if (py == '0)
                    begin
                        ux_next = '0; uy_next = '0;
                    end
                    else
                    begin
                        ux_next = n_reg; uy_next = e_reg;
                    end
                end
                else if (ret_reg == ecpsm_pkg::S_PA_CHECK)
                begin
                    rx_next = n_reg; ry_next = e_reg;
                end
                else if (px == '0 && py == '0)
                begin
                    rx_next = qx; ry_next = qy;
                end
                else if (qx == '0 && qy == '0)
                begin
                    rx_next = px; ry_next = py;
                end
                else if (px == qx)
                begin
                    rx_next = '0; ry_next = '0;
                end
                else
                begin
                    rx_next = n_reg; ry_next = e_reg;
                end
                ret_next = ecpsm_pkg::S_IDLE;
                dbl_next = 1'b0;
            end
            ecpsm_pkg::S_OUT:
            begin
                ov_next = 1'b1;
                ox_next = (p_reg < W'(3)) ? '0 : rx_reg;
                oy_next = (p_reg < W'(3)) ? '0 : ry_reg;
            end
            default: ;
        endcase
    end

    // scalar flow: after a doubling of the power, add it into R if the bit is set
    ecpsm_pkg::state_t state_adj;
    always_comb
    begin
        state_adj = state_next;
        if (state_reg == ecpsm_pkg::S_PA_DONE && sc_reg && dbl_reg &&
            ret_reg != ecpsm_pkg::S_PA_CHECK && m_reg[0])
            state_adj = ecpsm_pkg::S_PA_CHECK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ecpsm_pkg::S_IDLE;
            ret_reg   <= ecpsm_pkg::S_IDLE;
            go_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            sc_reg    <= 1'b0;
            dbl_reg   <= 1'b0;
            ic_reg    <= '0;
        end
        else
        begin
            state_reg <= state_adj;
            ret_reg   <= ret_next;
            go_reg    <= go_next || (state_adj != state_next);
            ov_reg    <= ov_next;
            sc_reg    <= sc_next;
            dbl_reg   <= dbl_next;
            ic_reg    <= ic_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ca_reg <= ca_next; ux_reg <= ux_next; uy_reg <= uy_next;
        vx_reg <= vx_next; vy_reg <= vy_next; rx_reg <= rx_next; ry_reg <= ry_next;
        m_reg <= m_next; t_reg <= t_next; n_reg <= n_next; l_reg <= l_next;
        e_reg <= e_next; ox_reg <= ox_next; oy_reg <= oy_next;
    end
endmodule
`default_nettype wire

/* hdl/ecpsm_fu.sv */
// ecpsm_fu: bit-serial modular arithmetic unit (add, sub, mul, reduce).
// Depends on ecpsm_pkg. Mul and reduce take one operand bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ecpsm_fu #(
    parameter int W = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ecpsm_pkg::fu_cmd_t cmd,
    input  wire logic [W-1:0]      opa,
    input  wire logic [W-1:0]      opb,
    input  wire logic [W-1:0]      modulus,
    output logic                   done,
    output logic [W-1:0]           res
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic          red_reg, red_next;

    logic [W:0]    dbl;
    logic [W-1:0]  dbl_m;
    logic [W:0]    sum;
    logic [W-1:0]  sum_m;
    logic [W:0]    add_s;
    logic [W:0]    sub_d;

    // acc*2 mod p (acc < p), with the top bit of b shifted in when reducing; acc*2 + a mod p; opa+opb, opa-opb
    always_comb
    begin
        dbl   = {acc_reg, 1'b0};
        dbl_m = (dbl >= {1'b0, modulus}) ? W'(dbl - {1'b0, modulus}) : dbl[W-1:0];
        if (red_reg)
        begin
            dbl   = {acc_reg, b_reg[W-1]};
            dbl_m = (dbl >= {1'b0, modulus}) ? W'(dbl - {1'b0, modulus}) : dbl[W-1:0];
        end
        sum   = {1'b0, dbl_m} + {1'b0, a_reg};
        sum_m = (sum >= {1'b0, modulus}) ? W'(sum - {1'b0, modulus}) : sum[W-1:0];
        add_s = {1'b0, opa} + {1'b0, opb};
        sub_d = {1'b0, opa} - {1'b0, opb};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        red_next  = red_reg;
        if (cmd.start)
        begin
            case (cmd.op)
                ecpsm_pkg::FOP_ADD:
                begin
                    acc_next  = (add_s >= {1'b0, modulus}) ? W'(add_s - {1'b0, modulus})
                                                          : add_s[W-1:0];
                    done_next = 1'b1;
                end
                ecpsm_pkg::FOP_SUB:
                begin
                    acc_next  = sub_d[W] ? W'(sub_d + {1'b0, modulus}) : sub_d[W-1:0];
                    done_next = 1'b1;
                end
                default:
                begin
                    busy_next = 1'b1;
                    cnt_next  = CW'(W);
                    acc_next  = '0;
                    a_next    = opa;
                    b_next    = opb;
                    red_next  = (cmd.op == ecpsm_pkg::FOP_RED);
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (red_reg)
                acc_next = dbl_m;
            else
                acc_next = b_reg[W-1] ? sum_m : dbl_m;
            b_next   = {b_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        red_reg <= red_next;
    end

    assign done = done_reg;
    assign res  = acc_reg;
endmodule
`default_nettype wire

/* hdl/ecpsm_checker.sv */
// ecpsm_checker: port-level assertions for ec_point_add_scalar_mult, with bind.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none
module ecpsm_checker #(
    parameter int FIELD_WIDTH = 64
) (
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     s_axis_tvalid,
    input wire logic                     s_axis_tready,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [8*((2*FIELD_WIDTH+7)/8)-1:0] m_axis_tdata,
    input wire logic                     m_axis_tuser
);
    a_inf_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata == '0)))
        else $error("at_infinity does not match zero point");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while a result is pending");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("unit ready right after accepting a request");
endmodule

bind ec_point_add_scalar_mult ecpsm_checker #(.FIELD_WIDTH(FIELD_WIDTH)) u_ecpsm_checker (
    .clk(clk), .rst_n(rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire
